[hdl/lu_linear_solver_assert.svh]
// Assertion macros for the solver modules.
// Included by lus_ctrl, which checks its own control logic.
`ifndef LU_LINEAR_SOLVER_ASSERT_SVH
`define LU_LINEAR_SOLVER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LUS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LUS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lus_pkg.sv]
// Package for the LU solver: datapath opcodes, command and status types,
// and the saturation helper. No dependencies.
package lus_pkg;

   localparam int CNT_W = 5;
   localparam int ACC_W = 40;
   localparam int OP_W  = 5;

   localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
   localparam logic [OP_W-1:0] OP_COPY  = 5'd2;
   localparam logic [OP_W-1:0] OP_CAPP  = 5'd3;
   localparam logic [OP_W-1:0] OP_DIVA  = 5'd4;
   localparam logic [OP_W-1:0] OP_DIVWR = 5'd5;
   localparam logic [OP_W-1:0] OP_CAPA  = 5'd6;
   localparam logic [OP_W-1:0] OP_CAPB  = 5'd7;
   localparam logic [OP_W-1:0] OP_EMUL  = 5'd8;
   localparam logic [OP_W-1:0] OP_RND   = 5'd9;
   localparam logic [OP_W-1:0] OP_EWR   = 5'd10;
   localparam logic [OP_W-1:0] OP_ACLR  = 5'd11;
   localparam logic [OP_W-1:0] OP_ACC   = 5'd12;
   localparam logic [OP_W-1:0] OP_VMULY = 5'd13;
   localparam logic [OP_W-1:0] OP_VMULX = 5'd14;
   localparam logic [OP_W-1:0] OP_FSUB  = 5'd15;
   localparam logic [OP_W-1:0] OP_FDIV  = 5'd16;
   localparam logic [OP_W-1:0] OP_YWR   = 5'd17;
   localparam logic [OP_W-1:0] OP_BSUB  = 5'd18;
   localparam logic [OP_W-1:0] OP_OCAP  = 5'd19;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
      logic [CNT_W-1:0] vidx;
      logic             fin;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               ovf;
   } sat_type;

   function automatic sat_type sat_to_32(input logic signed [63:0] v);
      sat_type r;
      if (v > 64'sd2147483647) begin
         r.value = 32'sh7fffffff;
         r.ovf   = 1'b1;
      end else if (v < -64'sd2147483648) begin
         r.value = 32'sh80000000;
         r.ovf   = 1'b1;
      end else begin
         r.value = v[31:0];
         r.ovf   = 1'b0;
      end
      return r;
   endfunction

endpackage

[hdl/lus_if.sv]
// Channel interfaces of the LU solver: load requests, solution responses
// and the size register write port. No dependencies.
interface lus_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [3:0]         row_index;
   logic [3:0]         col_index;
   logic signed [31:0] value;
   logic               last;
   modport source (output valid, kind, row_index, col_index, value, last, input ready);
   modport sink   (input valid, kind, row_index, col_index, value, last, output ready);
endinterface

interface lus_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         index;
   logic signed [31:0] solution;
   logic               final_res;
   logic               singular;
   logic               overflow;
   modport source (output valid, index, solution, final_res, singular, overflow,
                   input ready);
   modport sink   (input valid, index, solution, final_res, singular, overflow,
                   output ready);
endinterface

interface lus_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[hdl/lus_div.sv]
// Radix-2 restoring divider for the solver: (a << FRAC_BITS) / d,
// truncated toward zero and saturated to 32 bits. Uses lus_pkg.
module lus_div import lus_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [31:0] quotient,
   output logic               ovf,
   output logic               zero_div
);
   localparam int NW  = 32 + FRAC_BITS;
   localparam int CW  = $clog2(NW + 1);
   localparam logic [NW-1:0] LIM_POS = NW'(32'h7fffffff);
   localparam logic [NW-1:0] LIM_NEG = NW'(32'h80000000);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   rem_ff, rem_in;
   logic [NW-1:0] sh_ff, sh_in;
   logic [31:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic signed [31:0] quo_ff, quo_in;
   logic          ovf_ff, ovf_in;
   logic          dz_ff, dz_in;
   logic [32:0]   trial;
   logic [31:0]   mag_a, mag_d;

   assign mag_a = dividend[31] ? 32'(-dividend) : 32'(dividend);
   assign mag_d = divisor[31] ? 32'(-divisor) : 32'(divisor);
   assign trial = {rem_ff, sh_ff[NW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      dz_in   = dz_ff;
      if (start) begin
         ovf_in = 1'b0;
         if (divisor == 32'sd0) begin
            done_in = 1'b1;
            quo_in  = 32'sd0;
            dz_in   = 1'b1;
         end else begin
            busy_in = 1'b1;
            dz_in   = 1'b0;
            cnt_in  = CW'(NW);
            rem_in  = 32'd0;
            sh_in   = NW'(mag_a) << FRAC_BITS;
            den_in  = mag_d;
            neg_in  = dividend[31] ^ divisor[31];
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 32'(trial - {1'b0, den_ff});
               sh_in  = {sh_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               sh_in  = {sh_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               if (sh_ff > LIM_NEG) begin
                  quo_in = 32'sh80000000;
                  ovf_in = 1'b1;
               end else begin
                  quo_in = -$signed(sh_ff[31:0]);
               end
            end else begin
               if (sh_ff > LIM_POS) begin
                  quo_in = 32'sh7fffffff;
                  ovf_in = 1'b1;
               end else begin
                  quo_in = $signed(sh_ff[31:0]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         dz_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ovf_ff  <= ovf_in;
         dz_ff   <= dz_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign ovf      = ovf_ff;
   assign zero_div = dz_ff;
endmodule

[hdl/lus_dpath.sv]
// Datapath of the LU solver: matrix and vector memories, multiplier,
// accumulator and the shared divider. Uses lus_pkg and lus_div.
module lus_dpath import lus_pkg::*; #(
   parameter int DIM       = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_valid,
   input  logic               req_kind,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   output logic [3:0]         rsp_index,
   output logic signed [31:0] rsp_solution,
   output logic               rsp_final_res,
   output logic               rsp_singular,
   output logic               rsp_overflow
);
   localparam int AW = $clog2(DIM * DIM);
   localparam int IW = $clog2(DIM);
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   logic signed [31:0] coeff_mem [DIM*DIM];
   logic signed [31:0] lu_mem [DIM*DIM];
   logic signed [31:0] rhs_mem [DIM];
   logic signed [31:0] y_mem [DIM];
   logic signed [31:0] x_mem [DIM];

   logic signed [31:0] coeff_q_ff, lu_q_ff, rhs_q_ff, y_q_ff, x_q_ff;
   logic               copy_wr_ff;
   logic [AW-1:0]      copy_addr_ff;
   logic signed [31:0] piv_ff, a_ff, b_ff, c_ff, mres_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic               sing_ff, sing_in;
   logic               ovf_ff, ovf_in;
   logic [3:0]         oidx_ff;
   logic signed [31:0] osol_ff;
   logic               ofin_ff;

   logic               load_fire;
   logic [AW-1:0]      lu_addr, ld_addr;
   logic [IW-1:0]      vaddr;
   logic signed [31:0] ma, mb;
   logic               div_start, div_done, div_ovf, div_dz;
   logic signed [31:0] div_a, div_d, div_q;
   sat_type            rnd_s, ewr_s, fsub_s, bsub_s;
   logic signed [63:0] rnd_v;

   assign load_fire = (cmd.op == OP_LOAD) && req_valid;
   assign lu_addr   = AW'(cmd.row * DIM + cmd.col);
   assign ld_addr   = AW'(req_row_index * DIM + req_col_index);
   assign vaddr     = IW'(cmd.vidx);

   // Loaded matrix, read only by the copy sweep into the working matrix.
   always_ff @(posedge clock) begin
      if (load_fire && !req_kind && (32'(req_row_index) < DIM)
          && (32'(req_col_index) < DIM)) begin
         coeff_mem[ld_addr] <= req_value;
      end
      coeff_q_ff <= coeff_mem[lu_addr];
   end

   // Working matrix: L below and on the diagonal, U above it.
   always_ff @(posedge clock) begin
      if (copy_wr_ff) begin
         lu_mem[copy_addr_ff] <= coeff_q_ff;
      end else if (cmd.op == OP_DIVWR) begin
         lu_mem[lu_addr] <= div_q;
      end else if (cmd.op == OP_EWR) begin
         lu_mem[lu_addr] <= ewr_s.value;
      end
      lu_q_ff <= lu_mem[lu_addr];
   end

   always_ff @(posedge clock) begin
      if (load_fire && req_kind && (32'(req_row_index) < DIM)) begin
         rhs_mem[IW'(req_row_index)] <= req_value;
      end
      rhs_q_ff <= rhs_mem[vaddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_YWR) begin
         y_mem[vaddr] <= div_q;
      end
      y_q_ff <= y_mem[vaddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_BSUB) begin
         x_mem[vaddr] <= bsub_s.value;
      end
      x_q_ff <= x_mem[vaddr];
   end

   always_comb begin
      ma = lu_q_ff;
      mb = y_q_ff;
      case (cmd.op)
         OP_EMUL: begin
            ma = a_ff;
            mb = b_ff;
         end
         OP_VMULX: mb = x_q_ff;
         default: mb = y_q_ff;
      endcase
   end

   assign rnd_v  = (prod_ff + HALF) >>> FRAC_BITS;
   assign rnd_s  = sat_to_32(rnd_v);
   assign ewr_s  = sat_to_32(64'(c_ff) - 64'(mres_ff));
   assign fsub_s = sat_to_32(64'(rhs_q_ff) - 64'(acc_ff));
   assign bsub_s = sat_to_32(64'(y_q_ff) - 64'(acc_ff));

   assign div_start = (cmd.op == OP_DIVA) || (cmd.op == OP_FDIV);
   assign div_a     = (cmd.op == OP_FDIV) ? a_ff : lu_q_ff;
   assign div_d     = piv_ff;

   lus_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q),
      .ovf      (div_ovf),
      .zero_div (div_dz)
   );

   always_comb begin
      sing_in = sing_ff;
      ovf_in  = ovf_ff;
      if (load_fire && req_last) begin
         sing_in = 1'b0;
         ovf_in  = 1'b0;
      end else begin
         if ((cmd.op == OP_CAPP) && (lu_q_ff == 32'sd0)) sing_in = 1'b1;
         if (div_done && div_dz) sing_in = 1'b1;
         if (div_done && div_ovf) ovf_in = 1'b1;
         if ((cmd.op == OP_RND) && rnd_s.ovf) ovf_in = 1'b1;
         if ((cmd.op == OP_EWR) && ewr_s.ovf) ovf_in = 1'b1;
         if ((cmd.op == OP_FSUB) && fsub_s.ovf) ovf_in = 1'b1;
         if ((cmd.op == OP_BSUB) && bsub_s.ovf) ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_wr_ff <= 1'b0;
         sing_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         copy_wr_ff <= (cmd.op == OP_COPY);
         sing_ff    <= sing_in;
         ovf_ff     <= ovf_in;
      end
      copy_addr_ff <= lu_addr;
      case (cmd.op)
         OP_CAPP: piv_ff <= lu_q_ff;
         OP_CAPA: a_ff <= lu_q_ff;
         OP_CAPB: b_ff <= lu_q_ff;
         OP_EMUL: begin
            c_ff    <= lu_q_ff;
            prod_ff <= 64'(ma) * 64'(mb);
         end
         OP_VMULY, OP_VMULX: prod_ff <= 64'(ma) * 64'(mb);
         OP_RND: mres_ff <= rnd_s.value;
         OP_ACLR: acc_ff <= '0;
         OP_ACC: acc_ff <= acc_ff + ACC_W'(mres_ff);
         OP_FSUB: begin
            a_ff   <= fsub_s.value;
            piv_ff <= lu_q_ff;
         end
         OP_OCAP: begin
            oidx_ff <= cmd.vidx[3:0];
            osol_ff <= x_q_ff;
            ofin_ff <= cmd.fin;
         end
         default: begin
         end
      endcase
   end

   assign status.div_done = div_done;
   assign rsp_index       = oidx_ff;
   assign rsp_solution    = osol_ff;
   assign rsp_final_res   = ofin_ff;
   assign rsp_singular    = sing_ff;
   assign rsp_overflow    = ovf_ff;
endmodule

[hdl/lus_ctrl.sv]
// Sequencer of the LU solver: load, copy, factor, substitute and emit.
// Drives the datapath through cmd_type commands. Uses lus_pkg.
module lus_ctrl import lus_pkg::*; #(
   parameter int DIM = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic [4:0] csr_data,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   `include "lu_linear_solver_assert.svh"

   localparam int CAP = (DIM < 16) ? DIM : 16;
   localparam logic [CNT_W-1:0] CAP5 = CNT_W'(CAP);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_COPY    = 5'd1;
   localparam logic [4:0] S_COPYEND = 5'd2;
   localparam logic [4:0] S_PRD     = 5'd3;
   localparam logic [4:0] S_PCAP    = 5'd4;
   localparam logic [4:0] S_DCHK    = 5'd5;
   localparam logic [4:0] S_DSTART  = 5'd6;
   localparam logic [4:0] S_DWAIT   = 5'd7;
   localparam logic [4:0] S_DWR     = 5'd8;
   localparam logic [4:0] S_ECHK    = 5'd9;
   localparam logic [4:0] S_E2      = 5'd10;
   localparam logic [4:0] S_E3      = 5'd11;
   localparam logic [4:0] S_E4      = 5'd12;
   localparam logic [4:0] S_E5      = 5'd13;
   localparam logic [4:0] S_E6      = 5'd14;
   localparam logic [4:0] S_VINIT   = 5'd15;
   localparam logic [4:0] S_VCHK    = 5'd16;
   localparam logic [4:0] S_VMUL    = 5'd17;
   localparam logic [4:0] S_VRND    = 5'd18;
   localparam logic [4:0] S_VACC    = 5'd19;
   localparam logic [4:0] S_VB      = 5'd20;
   localparam logic [4:0] S_VSUB    = 5'd21;
   localparam logic [4:0] S_VDIV    = 5'd22;
   localparam logic [4:0] S_VWAIT   = 5'd23;
   localparam logic [4:0] S_VWR     = 5'd24;
   localparam logic [4:0] S_BINIT   = 5'd25;
   localparam logic [4:0] S_BCHK    = 5'd26;
   localparam logic [4:0] S_BMUL    = 5'd27;
   localparam logic [4:0] S_BRND    = 5'd28;
   localparam logic [4:0] S_BACC    = 5'd29;
   localparam logic [4:0] S_BY      = 5'd30;
   localparam logic [4:0] S_BSUB    = 5'd31;

   // Emit states live in a second code space selected by out_mode_ff.
   localparam logic [4:0] S_ORD     = 5'd0;
   localparam logic [4:0] S_OCAP    = 5'd1;
   localparam logic [4:0] S_OHOLD   = 5'd2;

   logic [4:0]       state_ff, state_in;
   logic             out_mode_ff, out_mode_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, n_ff, n_in;
   logic [4:0]       size_ff, size_in;
   logic [CNT_W-1:0] n_clamp, i_next, j_next, k_next, n_last;

   assign n_clamp = (size_ff == 5'd0) ? CNT_W'(1) : ((size_ff > CAP5) ? CAP5 : size_ff);
   assign i_next  = i_ff + 1'b1;
   assign j_next  = j_ff + 1'b1;
   assign k_next  = k_ff + 1'b1;
   assign n_last  = n_ff - 1'b1;

   always_comb begin
      state_in    = state_ff;
      out_mode_in = out_mode_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      size_in     = csr_valid ? csr_data : size_ff;
      cmd         = '0;
      cmd.op      = OP_NOP;
      if (out_mode_ff) begin
         cmd.vidx = i_ff;
         case (state_ff)
            S_ORD: state_in = S_OCAP;
            S_OCAP: begin
               cmd.op   = OP_OCAP;
               cmd.fin  = (i_next == n_ff);
               state_in = S_OHOLD;
            end
            S_OHOLD: begin
               if (rsp_ready) begin
                  if (i_next == n_ff) begin
                     out_mode_in = 1'b0;
                     state_in    = S_IDLE;
                  end else begin
                     i_in     = i_next;
                     state_in = S_ORD;
                  end
               end
            end
            default: state_in = S_ORD;
         endcase
      end else begin
         case (state_ff)
            S_IDLE: begin
               cmd.op = OP_LOAD;
               if (req_valid && req_last) begin
                  n_in     = n_clamp;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = S_COPY;
               end
            end
            S_COPY: begin
               cmd.op  = OP_COPY;
               cmd.row = i_ff;
               cmd.col = j_ff;
               if (j_ff == n_last) begin
                  j_in = '0;
                  if (i_ff == n_last) state_in = S_COPYEND;
                  else i_in = i_next;
               end else begin
                  j_in = j_next;
               end
            end
            S_COPYEND: begin
               i_in     = '0;
               state_in = S_PRD;
            end
            S_PRD: begin
               cmd.row  = i_ff;
               cmd.col  = i_ff;
               state_in = S_PCAP;
            end
            S_PCAP: begin
               cmd.op   = OP_CAPP;
               j_in     = i_next;
               state_in = S_DCHK;
            end
            S_DCHK: begin
               cmd.row = i_ff;
               cmd.col = j_ff;
               if (j_ff < n_ff) begin
                  state_in = S_DSTART;
               end else begin
                  j_in     = i_next;
                  k_in     = i_next;
                  state_in = S_ECHK;
               end
            end
            S_DSTART: begin
               cmd.op   = OP_DIVA;
               state_in = S_DWAIT;
            end
            S_DWAIT: if (status.div_done) state_in = S_DWR;
            S_DWR: begin
               cmd.op   = OP_DIVWR;
               cmd.row  = i_ff;
               cmd.col  = j_ff;
               j_in     = j_next;
               state_in = S_DCHK;
            end
            S_ECHK: begin
               cmd.row = j_ff;
               cmd.col = i_ff;
               if (j_ff < n_ff) begin
                  state_in = S_E2;
               end else if (i_next == n_ff) begin
                  i_in     = '0;
                  state_in = S_VINIT;
               end else begin
                  i_in     = i_next;
                  state_in = S_PRD;
               end
            end
            S_E2: begin
               cmd.op   = OP_CAPA;
               cmd.row  = i_ff;
               cmd.col  = k_ff;
               state_in = S_E3;
            end
            S_E3: begin
               cmd.op   = OP_CAPB;
               cmd.row  = j_ff;
               cmd.col  = k_ff;
               state_in = S_E4;
            end
            S_E4: begin
               cmd.op   = OP_EMUL;
               state_in = S_E5;
            end
            S_E5: begin
               cmd.op   = OP_RND;
               state_in = S_E6;
            end
            S_E6: begin
               cmd.op  = OP_EWR;
               cmd.row = j_ff;
               cmd.col = k_ff;
               if (k_next < n_ff) begin
                  k_in = k_next;
               end else begin
                  k_in = i_next;
                  j_in = j_next;
               end
               state_in = S_ECHK;
            end
            S_VINIT: begin
               cmd.op   = OP_ACLR;
               k_in     = '0;
               state_in = S_VCHK;
            end
            S_VCHK: begin
               cmd.row  = i_ff;
               cmd.col  = k_ff;
               cmd.vidx = k_ff;
               state_in = (k_ff < i_ff) ? S_VMUL : S_VB;
            end
            S_VMUL: begin
               cmd.op   = OP_VMULY;
               state_in = S_VRND;
            end
            S_VRND: begin
               cmd.op   = OP_RND;
               state_in = S_VACC;
            end
            S_VACC: begin
               cmd.op   = OP_ACC;
               k_in     = k_next;
               state_in = S_VCHK;
            end
            S_VB: begin
               cmd.row  = i_ff;
               cmd.col  = i_ff;
               cmd.vidx = i_ff;
               state_in = S_VSUB;
            end
            S_VSUB: begin
               cmd.op   = OP_FSUB;
               state_in = S_VDIV;
            end
            S_VDIV: begin
               cmd.op   = OP_FDIV;
               state_in = S_VWAIT;
            end
            S_VWAIT: if (status.div_done) state_in = S_VWR;
            S_VWR: begin
               cmd.op   = OP_YWR;
               cmd.vidx = i_ff;
               if (i_next == n_ff) begin
                  i_in     = n_last;
                  state_in = S_BINIT;
               end else begin
                  i_in     = i_next;
                  state_in = S_VINIT;
               end
            end
            S_BINIT: begin
               cmd.op   = OP_ACLR;
               k_in     = i_next;
               state_in = S_BCHK;
            end
            S_BCHK: begin
               cmd.row  = i_ff;
               cmd.col  = k_ff;
               cmd.vidx = k_ff;
               state_in = (k_ff < n_ff) ? S_BMUL : S_BY;
            end
            S_BMUL: begin
               cmd.op   = OP_VMULX;
               state_in = S_BRND;
            end
            S_BRND: begin
               cmd.op   = OP_RND;
               state_in = S_BACC;
            end
            S_BACC: begin
               cmd.op   = OP_ACC;
               k_in     = k_next;
               state_in = S_BCHK;
            end
            S_BY: begin
               cmd.vidx = i_ff;
               state_in = S_BSUB;
            end
            S_BSUB: begin
               cmd.op   = OP_BSUB;
               cmd.vidx = i_ff;
               if (i_ff == '0) begin
                  out_mode_in = 1'b1;
                  state_in    = S_ORD;
               end else begin
                  i_in     = i_ff - 1'b1;
                  state_in = S_BINIT;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         out_mode_ff <= 1'b0;
         size_ff     <= 5'd16;
         n_ff        <= CNT_W'(1);
      end else begin
         state_ff    <= state_in;
         out_mode_ff <= out_mode_in;
         size_ff     <= size_in;
         n_ff        <= n_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   assign req_ready = !out_mode_ff && (state_ff == S_IDLE);
   assign rsp_valid = out_mode_ff && (state_ff == S_OHOLD);

   `LUS_ASSERT_IMPL(a_ready_rsp_excl, clock, reset, req_ready, !rsp_valid,
                    "load ready while a solution transaction is pending")
   `LUS_ASSERT_IMPL(a_div_done_wait, clock, reset, status.div_done,
                    !out_mode_ff && ((state_ff == S_DWAIT) || (state_ff == S_VWAIT)),
                    "divider finished outside a wait state")
   `LUS_ASSERT_IMPL(a_order_range, clock, reset, !req_ready,
                    (n_ff != '0) && (n_ff <= CAP5), "system order out of range")
   `LUS_ASSERT_NEXT(a_last_rsp_idle, clock, reset,
                    rsp_valid && rsp_ready && (i_next == n_ff), req_ready,
                    "block not ready after the final solution transaction")
endmodule

[hdl/lu_linear_solver.sv]
// Top level of the LU solver: channel wiring, sequencer and datapath.
// Depends on lus_pkg, lus_if, lus_ctrl, lus_dpath and lus_div.
//
//  channel   dir  handshake     carries
//  req_chan  in   valid/ready   kind, row_index, col_index, value, last
//  rsp_chan  out  valid/ready   index, solution, final_res, singular, overflow
//  csr_chan  in   valid/ready   data (size_in_use), always ready
//
// A load completes when valid and ready are both high; ready stays high until a
// transaction with last. A solve of order n copies n*n words, factors them with
// the bit-serial divider, runs forward and back substitution, then emits the
// solutions one at a time, each through the ORD, OCAP and OHOLD emit states.
// Reset is synchronous; memories are not cleared. A stalled response holds
// the sequencer, and loads are refused from last until the final response.
module lu_linear_solver import lus_pkg::*; #(
   parameter int DIM       = 16,
   parameter int FRAC_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   lus_req_if.sink  req_chan,
   lus_rsp_if.source rsp_chan,
   lus_csr_if.sink  csr_chan
);
   cmd_type    cmd;
   status_type status;

   assign csr_chan.ready = 1'b1;

   lus_ctrl #(.DIM(DIM)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_data  (csr_chan.data),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lus_dpath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_valid     (req_chan.valid),
      .req_kind      (req_chan.kind),
      .req_row_index (req_chan.row_index),
      .req_col_index (req_chan.col_index),
      .req_value     (req_chan.value),
      .req_last      (req_chan.last),
      .rsp_index     (rsp_chan.index),
      .rsp_solution  (rsp_chan.solution),
      .rsp_final_res (rsp_chan.final_res),
      .rsp_singular  (rsp_chan.singular),
      .rsp_overflow  (rsp_chan.overflow)
   );
endmodule

[verif/lu_linear_solver_test.sv]
// Self-checking testbench for lu_linear_solver: loads systems, solves them and
// compares each solution entry with an in-bench fixed-point LU solver.
// Depends on lus_pkg, the channel interfaces in lus_if and the solver RTL.
module lu_linear_solver_test;
   import lus_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ORDER_CAP   = 16;
   localparam int FRAC        = 16;
   localparam int ONE_Q       = 1 << FRAC;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 2500;

   typedef struct {
      bit               kind;
      bit [3:0]         row;
      bit [3:0]         col;
      logic signed [31:0] value;
      bit               last;
   } load_t;

   typedef struct {
      bit [3:0]         index;
      logic signed [31:0] solution;
      bit               final_res;
      bit               singular;
      bit               overflow;
   } entry_t;

   typedef struct {
      load_t            ld;
      int               order;
      bit               typed;
      logic signed [31:0] x;
      bit               sing;
      bit               ovf;
   } step_t;

   localparam bit MAT = 1'b0;
   localparam bit RHS = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lus_req_if req_chan();
   lus_rsp_if rsp_chan();
   lus_csr_if csr_chan();

   lu_linear_solver dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #2 clock = ~clock;

   // Solver state mirrored from the block.
   int       coef [ORDER_CAP][ORDER_CAP];
   int       rhs [ORDER_CAP];
   int       fwd [ORDER_CAP];
   int       sol [ORDER_CAP];
   bit       coef_set [ORDER_CAP][ORDER_CAP];
   bit       rhs_set [ORDER_CAP];
   bit       sat_seen;
   bit       zero_pivot;
   bit [4:0] size_reg = 5'd16;

   entry_t   expected_solutions[$];
   int       mismatches = 0;
   int       checked = 0;
   int       items_sent = 0;
   int       solves = 0;
   int       cycles = 0;
   bit       hold_req = 1'b0;
   int       burst_left = 0;

   function automatic int sat_word(input longint v);
      if (v > 64'sd2147483647) begin
         sat_seen = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat_seen = 1'b1;
         return 32'sh80000000;
      end
      return int'(v);
   endfunction

   function automatic int mul_q(input int a, input int b);
      longint p;
      p = longint'(a) * longint'(b) + (longint'(1) << (FRAC - 1));
      return sat_word(p >>> FRAC);
   endfunction

   function automatic int div_q(input int a, input int d);
      if (d == 0) begin
         zero_pivot = 1'b1;
         return 0;
      end
      return sat_word((longint'(a) <<< FRAC) / longint'(d));
   endfunction

   function automatic int order_of(input bit [4:0] sz);
      if (sz < 1) return 1;
      if (sz > ORDER_CAP) return ORDER_CAP;
      return sz;
   endfunction

   function automatic void solve_system(input int n);
      int     w [ORDER_CAP][ORDER_CAP];
      int     l [ORDER_CAP][ORDER_CAP];
      int     u [ORDER_CAP][ORDER_CAP];
      longint acc;
      entry_t e;
      sat_seen   = 1'b0;
      zero_pivot = 1'b0;
      w = coef;
      for (int i = 0; i < n; i++) begin
         l[i][i] = w[i][i];
         u[i][i] = ONE_Q;
         if (w[i][i] == 0) zero_pivot = 1'b1;
         for (int j = i + 1; j < n; j++) begin
            l[j][i] = w[j][i];
            u[i][j] = div_q(w[i][j], w[i][i]);
         end
         for (int j = i + 1; j < n; j++)
            for (int k = i + 1; k < n; k++)
               w[j][k] = sat_word(longint'(w[j][k]) - longint'(mul_q(l[j][i], u[i][k])));
      end
      for (int i = 0; i < n; i++) begin
         acc = 0;
         for (int k = 0; k < i; k++) acc += mul_q(l[i][k], fwd[k]);
         fwd[i] = div_q(sat_word(longint'(rhs[i]) - acc), l[i][i]);
      end
      for (int i = n - 1; i >= 0; i--) begin
         acc = 0;
         for (int k = i + 1; k < n; k++) acc += mul_q(u[i][k], sol[k]);
         sol[i] = sat_word(longint'(fwd[i]) - acc);
      end
      for (int i = 0; i < n; i++) begin
         e.index     = i;
         e.solution  = sol[i];
         e.final_res = (i == n - 1);
         e.singular  = zero_pivot;
         e.overflow  = sat_seen;
         expected_solutions.push_back(e);
      end
   endfunction

   function automatic void apply_load(input load_t ld);
      if (ld.kind == MAT) begin
         coef[ld.row][ld.col]     = ld.value;
         coef_set[ld.row][ld.col] = 1'b1;
      end else begin
         rhs[ld.row]     = ld.value;
         rhs_set[ld.row] = 1'b1;
      end
      if (ld.last) begin
         solves++;
         solve_system(order_of(size_reg));
      end
   endfunction

   function automatic bit all_loaded(input int n);
      for (int r = 0; r < n; r++) begin
         if (!rhs_set[r]) return 1'b0;
         for (int c = 0; c < n; c++)
            if (!coef_set[r][c]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic int rand_value();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3: return int'($urandom());
         default: return $urandom_range(0, 16 * ONE_Q) - 8 * ONE_Q;
      endcase
   endfunction

   // Offers one load and returns once the transaction has been accepted.
   task automatic offer(input load_t ld);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid     = 1'b1;
      req_chan.kind      = ld.kind;
      req_chan.row_index = ld.row;
      req_chan.col_index = ld.col;
      req_chan.value     = ld.value;
      req_chan.last      = ld.last;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      apply_load(ld);
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      wait (expected_solutions.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size(input bit [4:0] sz);
      drain();
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.data  = sz;
      do @(posedge clock); while (!csr_chan.ready);
      size_reg = sz;
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // Receiver: stalls follow a randomly redrawn mode, plus one long hold-off.
   initial begin
      int hold_left;
      int mode;
      hold_left = 0;
      mode = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (cycles % 64 == 0) mode = $urandom_range(0, 2);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            case (mode)
               0: rsp_chan.ready = 1'b1;
               1: rsp_chan.ready = $urandom_range(0, 1);
               default: rsp_chan.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      entry_t exp_e;
      cycles <= cycles + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         checked++;
         if (expected_solutions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected solution entry: index %0d value %h",
                        rsp_chan.index, rsp_chan.solution);
         end else begin
            exp_e = expected_solutions.pop_front();
            if (rsp_chan.index !== exp_e.index || rsp_chan.solution !== exp_e.solution ||
                rsp_chan.final_res !== exp_e.final_res ||
                rsp_chan.singular !== exp_e.singular ||
                rsp_chan.overflow !== exp_e.overflow) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("entry differs: exp idx %0d x %h fin %b sing %b ovf %b, got idx %0d x %h fin %b sing %b ovf %b",
                           exp_e.index, exp_e.solution, exp_e.final_res, exp_e.singular,
                           exp_e.overflow, rsp_chan.index, rsp_chan.solution,
                           rsp_chan.final_res, rsp_chan.singular, rsp_chan.overflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("lu_linear_solver: mismatch");
         $finish;
      end
   end

   step_t directed[$];

   function automatic step_t mk(input bit kind, input int row, input int col, input int value,
                                input bit last, input int order, input bit typed = 1'b0,
                                input int x = 0, input bit sing = 1'b0, input bit ovf = 1'b0);
      step_t s;
      s.ld.kind  = kind;
      s.ld.row   = row;
      s.ld.col   = col;
      s.ld.value = value;
      s.ld.last  = last;
      s.order    = order;
      s.typed    = typed;
      s.x        = x;
      s.sing     = sing;
      s.ovf      = ovf;
      return s;
   endfunction

   initial begin
      load_t  ld;
      entry_t typed_e;
      int     n;
      int     loads;
      bit     big_done;
      bit     hold_done;
      bit [4:0] sz;
      req_chan.valid     = 1'b0;
      req_chan.kind      = MAT;
      req_chan.row_index = '0;
      req_chan.col_index = '0;
      req_chan.value     = '0;
      req_chan.last      = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.data      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Order 1: plain divide, zero pivot, saturation both ways, sign handling.
      directed.push_back(mk(MAT, 0, 0, ONE_Q, 0, 1));
      directed.push_back(mk(RHS, 0, 0, 5 * ONE_Q, 1, 1, 1, 5 * ONE_Q));
      directed.push_back(mk(MAT, 0, 0, 0, 1, 1, 1, 0, 1, 0));
      directed.push_back(mk(MAT, 0, 0, 1, 0, 1));
      directed.push_back(mk(RHS, 0, 0, 32'sh7fffffff, 1, 1, 1, 32'sh7fffffff, 0, 1));
      directed.push_back(mk(RHS, 0, 0, 32'sh80000000, 1, 1, 1, 32'sh80000000, 0, 1));
      directed.push_back(mk(MAT, 0, 0, 32'sh7fffffff, 0, 1));
      directed.push_back(mk(RHS, 0, 0, 32'sh7fffffff, 1, 1, 1, ONE_Q));
      directed.push_back(mk(MAT, 0, 0, 32'sh80000000, 1, 1));
      directed.push_back(mk(MAT, 0, 0, -ONE_Q, 0, 1));
      directed.push_back(mk(RHS, 0, 0, -3 * ONE_Q, 1, 1, 1, 3 * ONE_Q));
      // Order 2: a regular system, then a zero leading pivot, then the rhs column ignored.
      directed.push_back(mk(MAT, 0, 0, 2 * ONE_Q, 0, 2));
      directed.push_back(mk(MAT, 0, 1, ONE_Q, 0, 2));
      directed.push_back(mk(MAT, 1, 0, ONE_Q, 0, 2));
      directed.push_back(mk(MAT, 1, 1, 3 * ONE_Q, 0, 2));
      directed.push_back(mk(RHS, 0, 0, 3 * ONE_Q, 0, 2));
      directed.push_back(mk(RHS, 1, 0, 4 * ONE_Q, 1, 2));
      directed.push_back(mk(MAT, 0, 0, 0, 1, 2));
      directed.push_back(mk(MAT, 0, 0, ONE_Q, 0, 2));
      directed.push_back(mk(RHS, 1, 15, -7 * ONE_Q, 1, 2));
      // A size of zero solves order one.
      directed.push_back(mk(RHS, 0, 0, 2 * ONE_Q, 1, 0, 1, 2 * ONE_Q));

      foreach (directed[i]) begin
         if (directed[i].order != size_reg) write_size(directed[i].order);
         offer(directed[i].ld);
         if (directed[i].typed) begin
            typed_e = expected_solutions.pop_back();
            typed_e.solution = directed[i].x;
            typed_e.singular = directed[i].sing;
            typed_e.overflow = directed[i].ovf;
            expected_solutions.push_back(typed_e);
         end
      end

      big_done  = 1'b0;
      hold_done = 1'b0;
      while (items_sent < 380) begin
         if (!big_done && items_sent > 60) begin
            sz = 5'd31;
            big_done = 1'b1;
         end else if ($urandom_range(0, 9) < 7) begin
            sz = $urandom_range(1, 4);
         end else begin
            sz = $urandom_range(5, 8);
         end
         write_size(sz);
         n = order_of(sz);
         repeat ($urandom_range(2, 5)) begin
            if (!all_loaded(n)) begin
               for (int r = 0; r < n; r++) begin
                  for (int c = 0; c < n; c++) begin
                     ld.kind  = MAT;
                     ld.row   = r;
                     ld.col   = c;
                     ld.value = (r == c && $urandom_range(0, 3) != 0)
                                ? $urandom_range(2 * ONE_Q, 20 * ONE_Q) : rand_value();
                     ld.last  = 1'b0;
                     offer(ld);
                  end
                  ld.kind  = RHS;
                  ld.col   = $urandom_range(0, 15);
                  ld.value = rand_value();
                  offer(ld);
               end
            end else begin
               loads = $urandom_range(0, 2 * n);
               repeat (loads) begin
                  ld.kind  = $urandom_range(0, 1);
                  // A few writes land outside the active order; they are kept for later.
                  ld.row   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, n - 1);
                  ld.col   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, n - 1);
                  ld.value = rand_value();
                  ld.last  = 1'b0;
                  offer(ld);
               end
            end
            ld.kind  = $urandom_range(0, 1);
            ld.row   = $urandom_range(0, n - 1);
            ld.col   = $urandom_range(0, n - 1);
            ld.value = rand_value();
            ld.last  = 1'b1;
            offer(ld);
            if (!hold_done && solves > 30) begin
               hold_done = 1'b1;
               hold_req  = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) drain();
         end
      end

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d loads and %0d solves with orders 1 to 16; %0d entries checked",
               items_sent, solves, checked);
      if (mismatches == 0 && expected_solutions.size() == 0) begin
         $display("lu_linear_solver: match");
      end else begin
         $display("%0d mismatches, %0d entries never arrived", mismatches,
                  expected_solutions.size());
         $display("lu_linear_solver: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/lus_pkg.sv
hdl/lus_if.sv
hdl/lus_div.sv
hdl/lus_dpath.sv
hdl/lus_ctrl.sv
hdl/lu_linear_solver.sv
verif/lu_linear_solver_test.sv
